/* design/crop_box_aspect_fit_core_defines.svh */
// Assertion macros shared by the crop box aspect fit core.
`ifndef CROP_BOX_ASPECT_FIT_CORE_DEFINES_SVH
`define CROP_BOX_ASPECT_FIT_CORE_DEFINES_SVH
`ifndef SYNTH
`define CBAF_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbaf: implication check failed");
`define CBAF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbaf: next-cycle check failed");
`else
`define CBAF_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define CBAF_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

/* design/cbaf_pkg.sv */
// Shared types, widths and codes of the crop box aspect fit core.
package cbaf_pkg;

   localparam int POS_W     = 12;
   localparam int LEN_W     = 13;
   localparam int PROD_W    = 2 * LEN_W;
   localparam int VAL_W     = PROD_W + 2;
   localparam int CSR_IDX_W = 2;

   localparam int IMAGE_DIM_MAX_DEF = 4096;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_WIDE   = 2'd1;
   localparam logic [1:0] MODE_NARROW = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 2'd3;

   typedef struct packed {
      logic [LEN_W-1:0] image_width;
      logic [LEN_W-1:0] image_height;
      logic [LEN_W-1:0] target_width;
      logic [LEN_W-1:0] target_height;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      image_width:   13'd640,
      image_height:  13'd480,
      target_width:  13'd32,
      target_height: 13'd32
   };

   // Box seen along the kept axis (a) and the grown axis (b).
   typedef struct packed {
      logic [1:0]       mode;
      logic [POS_W-1:0] a_pos;
      logic [POS_W-1:0] b_pos;
      logic [LEN_W-1:0] a_len;
      logic [LEN_W-1:0] b_len;
      logic [LEN_W-1:0] img_b;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [PROD_W-1:0] dvd1;
      logic [LEN_W-1:0]  dvs1;
      logic [PROD_W-1:0] dvd2;
      logic [LEN_W-1:0]  dvs2;
   } div_pay_type;

   typedef struct packed {
      logic        valid;
      div_pay_type pay;
   } div_req_type;

   typedef struct packed {
      logic              valid;
      side_type          side;
      logic [PROD_W-1:0] q1;
      logic [PROD_W-1:0] q2;
   } div_rsp_type;

endpackage

/* design/cbaf_front.sv */
// Front stages: ratio cross products, mode decision and divider operand selection.
module cbaf_front import cbaf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [POS_W-1:0]  box_x,
   input  logic [POS_W-1:0]  box_y,
   input  logic [LEN_W-1:0]  box_width,
   input  logic [LEN_W-1:0]  box_height,
   input  cfg_type           cfg,
   output div_req_type       div_req
);

   logic              s1_vld_ff;
   logic [POS_W-1:0]  s1_x_ff, s1_y_ff;
   logic [LEN_W-1:0]  s1_w_ff, s1_h_ff;
   logic [PROD_W-1:0] s1_wth_ff, s1_htw_ff, s1_ihtw_ff, s1_iwth_ff;

   logic              s2_vld_ff;
   div_pay_type       s2_pay_ff;
   div_pay_type       s2_pay_in;
   logic              ratio_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff    <= box_x;
      s1_y_ff    <= box_y;
      s1_w_ff    <= box_width;
      s1_h_ff    <= box_height;
      s1_wth_ff  <= PROD_W'(box_width) * PROD_W'(cfg.target_height);
      s1_htw_ff  <= PROD_W'(box_height) * PROD_W'(cfg.target_width);
      s1_ihtw_ff <= PROD_W'(cfg.image_height) * PROD_W'(cfg.target_width);
      s1_iwth_ff <= PROD_W'(cfg.image_width) * PROD_W'(cfg.target_height);
   end

   assign ratio_ok = (cfg.target_width != '0) && (cfg.target_height != '0);

   always_comb begin
      // default: ratio met or undefined, keep box as is
      s2_pay_in.side.mode  = MODE_PASS;
      s2_pay_in.side.a_pos = s1_x_ff;
      s2_pay_in.side.b_pos = s1_y_ff;
      s2_pay_in.side.a_len = s1_w_ff;
      s2_pay_in.side.b_len = s1_h_ff;
      s2_pay_in.side.img_b = cfg.image_height;
      s2_pay_in.dvd1       = s1_wth_ff;
      s2_pay_in.dvs1       = cfg.target_width;
      s2_pay_in.dvd2       = s1_ihtw_ff;
      s2_pay_in.dvs2       = cfg.target_height;
      if (ratio_ok && (s1_wth_ff > s1_htw_ff)) begin
         s2_pay_in.side.mode = MODE_WIDE;
      end else if (ratio_ok && (s1_wth_ff < s1_htw_ff)) begin
         // too narrow: swap axes, grow the width
         s2_pay_in.side.mode  = MODE_NARROW;
         s2_pay_in.side.a_pos = s1_y_ff;
         s2_pay_in.side.b_pos = s1_x_ff;
         s2_pay_in.side.a_len = s1_h_ff;
         s2_pay_in.side.b_len = s1_w_ff;
         s2_pay_in.side.img_b = cfg.image_width;
         s2_pay_in.dvd1       = s1_htw_ff;
         s2_pay_in.dvs1       = cfg.target_height;
         s2_pay_in.dvd2       = s1_iwth_ff;
         s2_pay_in.dvs2       = cfg.target_width;
      end
   end

   always_ff @(posedge clock) begin
      s2_pay_ff <= s2_pay_in;
   end

   assign div_req.valid = s2_vld_ff;
   assign div_req.pay   = s2_pay_ff;

endmodule

/* design/cbaf_div_pair.sv */
// Two restoring dividers in lockstep, one quotient bit per pipeline stage.
module cbaf_div_pair import cbaf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEPS = PROD_W;

   typedef struct packed {
      logic             qbit;
      logic [LEN_W-1:0] rem;
   } step_type;

   function automatic step_type div_step(input logic [LEN_W-1:0] rem,
                                         input logic             bit_in,
                                         input logic [LEN_W-1:0] dvs);
      logic [LEN_W:0] trial;
      step_type       r;
      trial = {rem, bit_in};
      if (trial >= {1'b0, dvs}) begin
         r.qbit = 1'b1;
         r.rem  = LEN_W'(trial - {1'b0, dvs});
      end else begin
         r.qbit = 1'b0;
         r.rem  = trial[LEN_W-1:0];
      end
      return r;
   endfunction

   logic              vld_ff  [STEPS];
   side_type          side_ff [STEPS];
   logic [PROD_W-1:0] dvd1_ff [STEPS];
   logic [PROD_W-1:0] dvd2_ff [STEPS];
   logic [PROD_W-1:0] quo1_ff [STEPS];
   logic [PROD_W-1:0] quo2_ff [STEPS];
   logic [LEN_W-1:0]  rem1_ff [STEPS];
   logic [LEN_W-1:0]  rem2_ff [STEPS];
   logic [LEN_W-1:0]  dvs1_ff [STEPS];
   logic [LEN_W-1:0]  dvs2_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic              src_vld;
      side_type          src_side;
      logic [PROD_W-1:0] src_dvd1, src_dvd2, src_quo1, src_quo2;
      logic [LEN_W-1:0]  src_rem1, src_rem2, src_dvs1, src_dvs2;
      step_type          st1, st2;

      if (k == 0) begin : g_first
         assign src_vld  = req.valid;
         assign src_side = req.pay.side;
         assign src_dvd1 = req.pay.dvd1;
         assign src_dvd2 = req.pay.dvd2;
         assign src_quo1 = '0;
         assign src_quo2 = '0;
         assign src_rem1 = '0;
         assign src_rem2 = '0;
         assign src_dvs1 = req.pay.dvs1;
         assign src_dvs2 = req.pay.dvs2;
      end else begin : g_rest
         assign src_vld  = vld_ff[k-1];
         assign src_side = side_ff[k-1];
         assign src_dvd1 = dvd1_ff[k-1];
         assign src_dvd2 = dvd2_ff[k-1];
         assign src_quo1 = quo1_ff[k-1];
         assign src_quo2 = quo2_ff[k-1];
         assign src_rem1 = rem1_ff[k-1];
         assign src_rem2 = rem2_ff[k-1];
         assign src_dvs1 = dvs1_ff[k-1];
         assign src_dvs2 = dvs2_ff[k-1];
      end

      assign st1 = div_step(src_rem1, src_dvd1[PROD_W-1], src_dvs1);
      assign st2 = div_step(src_rem2, src_dvd2[PROD_W-1], src_dvs2);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= src_vld;
         end
      end

      // shift the next dividend bit in, the new quotient bit in at the bottom
      always_ff @(posedge clock) begin
         side_ff[k] <= src_side;
         dvd1_ff[k] <= {src_dvd1[PROD_W-2:0], 1'b0};
         dvd2_ff[k] <= {src_dvd2[PROD_W-2:0], 1'b0};
         quo1_ff[k] <= {src_quo1[PROD_W-2:0], st1.qbit};
         quo2_ff[k] <= {src_quo2[PROD_W-2:0], st2.qbit};
         rem1_ff[k] <= st1.rem;
         rem2_ff[k] <= st2.rem;
         dvs1_ff[k] <= src_dvs1;
         dvs2_ff[k] <= src_dvs2;
      end
   end

   assign rsp.valid = vld_ff[STEPS-1];
   assign rsp.side  = side_ff[STEPS-1];
   assign rsp.q1    = quo1_ff[STEPS-1];
   assign rsp.q2    = quo2_ff[STEPS-1];

endmodule

/* design/cbaf_back.sv */
// Back stages: center the grown side, fit it in the image, shrink on overflow, saturate.
`include "crop_box_aspect_fit_core_defines.svh"
module cbaf_back import cbaf_pkg::*; #(
   parameter int IMAGE_DIM_MAX = IMAGE_DIM_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  div_rsp_type       rsp,
   output logic              out_valid,
   output logic [POS_W-1:0]  fit_x,
   output logic [POS_W-1:0]  fit_y,
   output logic [LEN_W-1:0]  fit_width,
   output logic [LEN_W-1:0]  fit_height
);

   localparam logic signed [VAL_W-1:0] POS_HI = VAL_W'(IMAGE_DIM_MAX - 1);
   localparam logic signed [VAL_W-1:0] LEN_HI = VAL_W'(IMAGE_DIM_MAX);

   function automatic logic signed [VAL_W-1:0] clamp(input logic signed [VAL_W-1:0] v,
                                                     input logic signed [VAL_W-1:0] hi);
      if (v < 0) begin
         return '0;
      end else if (v > hi) begin
         return hi;
      end
      return v;
   endfunction

   // stage 1: half growth, overflow test, shrink difference
   logic                     b1_vld_ff;
   side_type                 b1_side_ff;
   logic [PROD_W-1:0]        b1_q1_ff, b1_q2_ff, b1_half_ff, b1_half_in;
   logic                     b1_ovf_ff, b1_ovf_in;
   logic signed [VAL_W-1:0]  b1_d2_ff, b1_d2_in;

   always_comb begin
      b1_half_in = (rsp.q1 - PROD_W'(rsp.side.b_len)) >> 1;
      b1_ovf_in  = rsp.q1 > PROD_W'(rsp.side.img_b);
      b1_d2_in   = $signed(VAL_W'(rsp.side.a_len)) - $signed(VAL_W'(rsp.q2));
   end

   always_ff @(posedge clock) begin
      b1_side_ff <= rsp.side;
      b1_q1_ff   <= rsp.q1;
      b1_q2_ff   <= rsp.q2;
      b1_half_ff <= b1_half_in;
      b1_ovf_ff  <= b1_ovf_in;
      b1_d2_ff   <= b1_d2_in;
   end

   // stage 2: centered position of the grown side, halved shrink (toward zero)
   logic                     b2_vld_ff;
   side_type                 b2_side_ff;
   logic [PROD_W-1:0]        b2_q1_ff, b2_q2_ff;
   logic                     b2_ovf_ff;
   logic signed [VAL_W-1:0]  b2_bpc_ff, b2_bpc_in, b2_adj_ff, b2_adj_in;
   logic signed [VAL_W-1:0]  bp_raw, d2_rnd;

   always_comb begin
      bp_raw    = $signed(VAL_W'(b1_side_ff.b_pos)) - $signed(VAL_W'(b1_half_ff));
      b2_bpc_in = (bp_raw < 0) ? '0 : bp_raw;
      d2_rnd    = b1_d2_ff + $signed(VAL_W'(b1_d2_ff[VAL_W-1]));
      b2_adj_in = d2_rnd >>> 1;
   end

   always_ff @(posedge clock) begin
      b2_side_ff <= b1_side_ff;
      b2_q1_ff   <= b1_q1_ff;
      b2_q2_ff   <= b1_q2_ff;
      b2_ovf_ff  <= b1_ovf_ff;
      b2_bpc_ff  <= b2_bpc_in;
      b2_adj_ff  <= b2_adj_in;
   end

   // stage 3: push back inside the image or take the full image side
   logic                     b3_vld_ff;
   side_type                 b3_side_ff;
   logic                     b3_ovf_ff;
   logic signed [VAL_W-1:0]  b3_apos_ff, b3_bpos_ff, b3_alen_ff, b3_blen_ff;
   logic signed [VAL_W-1:0]  b3_apos_in, b3_bpos_in, b3_alen_in, b3_blen_in;
   logic signed [VAL_W-1:0]  q1_s, img_s;

   always_comb begin
      q1_s       = $signed(VAL_W'(b2_q1_ff));
      img_s      = $signed(VAL_W'(b2_side_ff.img_b));
      b3_apos_in = $signed(VAL_W'(b2_side_ff.a_pos));
      b3_bpos_in = $signed(VAL_W'(b2_side_ff.b_pos));
      b3_alen_in = $signed(VAL_W'(b2_side_ff.a_len));
      b3_blen_in = $signed(VAL_W'(b2_side_ff.b_len));
      case (b2_side_ff.mode)
         MODE_WIDE, MODE_NARROW: begin
            if (b2_ovf_ff) begin
               b3_bpos_in = '0;
               b3_blen_in = img_s;
               b3_alen_in = $signed(VAL_W'(b2_q2_ff));
               b3_apos_in = b3_apos_in + b2_adj_ff;
            end else begin
               b3_blen_in = q1_s;
               b3_bpos_in = (b2_bpc_ff + q1_s > img_s) ? (img_s - q1_s) : b2_bpc_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b3_side_ff <= b2_side_ff;
      b3_ovf_ff  <= b2_ovf_ff;
      b3_apos_ff <= b3_apos_in;
      b3_bpos_ff <= b3_bpos_in;
      b3_alen_ff <= b3_alen_in;
      b3_blen_ff <= b3_blen_in;
   end

   // stage 4: swap axes back and saturate into the field ranges
   logic                     out_vld_ff;
   logic [POS_W-1:0]         fit_x_ff, fit_y_ff, fit_x_in, fit_y_in;
   logic [LEN_W-1:0]         fit_w_ff, fit_h_ff, fit_w_in, fit_h_in;
   logic signed [VAL_W-1:0]  x_v, y_v, w_v, h_v;

   always_comb begin
      if (b3_side_ff.mode == MODE_NARROW) begin
         x_v = b3_bpos_ff;
         y_v = b3_apos_ff;
         w_v = b3_blen_ff;
         h_v = b3_alen_ff;
      end else begin
         x_v = b3_apos_ff;
         y_v = b3_bpos_ff;
         w_v = b3_alen_ff;
         h_v = b3_blen_ff;
      end
      fit_x_in = POS_W'(clamp(x_v, POS_HI));
      fit_y_in = POS_W'(clamp(y_v, POS_HI));
      fit_w_in = LEN_W'(clamp(w_v, LEN_HI));
      fit_h_in = LEN_W'(clamp(h_v, LEN_HI));
   end

   always_ff @(posedge clock) begin
      fit_x_ff <= fit_x_in;
      fit_y_ff <= fit_y_in;
      fit_w_ff <= fit_w_in;
      fit_h_ff <= fit_h_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         b3_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         b1_vld_ff  <= rsp.valid;
         b2_vld_ff  <= b1_vld_ff;
         b3_vld_ff  <= b2_vld_ff;
         out_vld_ff <= b3_vld_ff;
      end
   end

   assign out_valid  = out_vld_ff;
   assign fit_x      = fit_x_ff;
   assign fit_y      = fit_y_ff;
   assign fit_width  = fit_w_ff;
   assign fit_height = fit_h_ff;

   `CBAF_ASSERT_IMPLY(ast_grown_side_inside, clock, reset, b3_vld_ff && (b3_side_ff.mode != MODE_PASS), (b3_bpos_ff >= 0) && (b3_bpos_ff + b3_blen_ff <= $signed(VAL_W'(b3_side_ff.img_b))))
   `CBAF_ASSERT_IMPLY(ast_grown_side_not_shorter, clock, reset, b3_vld_ff && (b3_side_ff.mode != MODE_PASS) && !b3_ovf_ff, b3_blen_ff >= $signed(VAL_W'(b3_side_ff.b_len)))
   `CBAF_ASSERT_IMPLY(ast_overflow_shrinks_kept_side, clock, reset, b3_vld_ff && (b3_side_ff.mode != MODE_PASS) && b3_ovf_ff, b3_alen_ff < $signed(VAL_W'(b3_side_ff.a_len)))

endmodule

/* design/crop_box_aspect_fit_core.sv */
// Top level of the crop box aspect fit core: register file and pipeline hookup.
//
// Usage:
//  - Request: drive req_box_* and raise start; the word is taken at a clock edge
//    with start high and busy low. busy is high only while reset is held, so a
//    new box can be taken at every edge.
//  - Result: rsp_valid is high for one cycle with rsp_fit_*; the receiver has no
//    way to hold it, and none is needed since nothing waits inside the block.
//  - Pipeline: the edge that takes the request loads the first of 32 register
//    stages (two front, one per quotient bit of the 26-bit dividers, four back);
//    the result word leaves the last of them. One box per cycle.
//  - Results leave in request order.
//  - Registers: csr_wr_en with csr_index and csr_wdata writes image_width,
//    image_height, target_width or target_height at the clock edge. Write only
//    while no box is in flight.
//  - Reset clears the pipeline valid bits and loads the register defaults
//    (640 x 480 image, 32 : 32 ratio).
module crop_box_aspect_fit_core import cbaf_pkg::*; #(
   parameter int IMAGE_DIM_MAX = IMAGE_DIM_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [POS_W-1:0]     req_box_x,
   input  logic [POS_W-1:0]     req_box_y,
   input  logic [LEN_W-1:0]     req_box_width,
   input  logic [LEN_W-1:0]     req_box_height,
   output logic                 rsp_valid,
   output logic [POS_W-1:0]     rsp_fit_x,
   output logic [POS_W-1:0]     rsp_fit_y,
   output logic [LEN_W-1:0]     rsp_fit_width,
   output logic [LEN_W-1:0]     rsp_fit_height,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LEN_W-1:0]     csr_wdata
);

   cfg_type     cfg_ff;
   logic        req_accept;
   div_req_type div_req;
   div_rsp_type div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_wdata;
            CSR_IMAGE_HEIGHT:  cfg_ff.image_height  <= csr_wdata;
            CSR_TARGET_WIDTH:  cfg_ff.target_width  <= csr_wdata;
            CSR_TARGET_HEIGHT: cfg_ff.target_height <= csr_wdata;
            default:           cfg_ff               <= cfg_ff;
         endcase
      end
   end

   assign busy       = reset;
   assign req_accept = start && !busy;

   cbaf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .box_x      (req_box_x),
      .box_y      (req_box_y),
      .box_width  (req_box_width),
      .box_height (req_box_height),
      .cfg        (cfg_ff),
      .div_req    (div_req)
   );

   cbaf_div_pair u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   cbaf_back #(
      .IMAGE_DIM_MAX (IMAGE_DIM_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .rsp        (div_rsp),
      .out_valid  (rsp_valid),
      .fit_x      (rsp_fit_x),
      .fit_y      (rsp_fit_y),
      .fit_width  (rsp_fit_width),
      .fit_height (rsp_fit_height)
   );

endmodule
